/* src/abswsc_pkg.sv */
// Shared constants and types for the ABS wheel slip controller.
package abswsc_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int WHL_IDX_W  = 2;

	localparam int SPEED_W  = 16;
	localparam int DEMAND_W = 12;
	localparam int TIME_W   = 32;
	localparam int SLIP_W   = 10;
	localparam int THR_W    = 10;
	localparam int PERIOD_W = 16;
	localparam int CUT_W    = 9;

	// tdata widths, padded to whole bytes
	localparam int IN_W  = 152;
	localparam int OUT_W = 112;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ABS_ENABLED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLIP_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_CUT    = 3'd4;

	// speeds at or below this never set the reference
	localparam logic [SPEED_W-1:0] MIN_VALID_SPEED = 16'd10;
	localparam logic [CUT_W-1:0]   CUT_FULL        = 9'd256;

	// divider: 26-bit dividend, 16-bit divisor, 10 quotient bits
	localparam int DVD_W = 26;
	localparam int DEN_W = 16;

	typedef logic [SPEED_W-1:0]  speed_t;
	typedef logic [DEMAND_W-1:0] demand_t;
	typedef logic [SLIP_W-1:0]   slip_t;
	typedef logic [TIME_W-1:0]   time_t;

endpackage

/* src/abs_wheel_slip_controller.sv */
// ABS wheel slip controller: top level with sequencer and shared serial divider.
//
//  channel  dir  signals                     payload
//  s_axis   in   s_tvalid s_tready s_tdata   one control tick (speeds, ok mask, time, demands)
//  m_axis   out  m_tvalid m_tready m_tdata   one result per tick
//  cfg      in   cfg_we cfg_index cfg_data   register write, one per cycle
//
// Each healthy wheel below the reference passes through the wheel, divide and update states,
// the divide in the one-bit-per-cycle restoring divider; the mean takes one more division,
// then brake scaling runs wheel by wheel on one shared 12x9 multiplier. s_tready is high only
// in idle. The result register holds until m_tready; no new tick is taken before that.
// arst_n clears the flags, pulse times and held slips and loads register defaults.
module abs_wheel_slip_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// wheel0..3_speed, sensor_ok_mask, time_ms, brake0..3_demand, zero pad
	input  logic [abswsc_pkg::IN_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// system_active, wheel_active_mask, pulse_mask, slip0..3, avg_slip,
	// brake0..3_out, zero pad
	output logic [abswsc_pkg::OUT_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [abswsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abswsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import abswsc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_REF   = 4'd1;
	localparam logic [3:0] ST_WHEEL = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_UPD   = 4'd4;
	localparam logic [3:0] ST_AVG   = 4'd5;
	localparam logic [3:0] ST_BRAKE = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0] state_q;

	// configuration
	logic                enabled_q;
	logic [THR_W-1:0]    thr_q;
	logic [SPEED_W-1:0]  min_speed_q;
	logic [PERIOD_W-1:0] period_q;
	logic [CUT_W-1:0]    cut_q;

	// captured tick
	speed_t              spd_q [NUM_WHEELS];
	demand_t             dem_q [NUM_WHEELS];
	logic [NUM_WHEELS-1:0] ok_q;
	time_t               now_q;

	// controller state
	logic [NUM_WHEELS-1:0] active_q;
	time_t               lpt_q  [NUM_WHEELS];
	slip_t               held_q [NUM_WHEELS];

	// per-tick working values
	logic [WHL_IDX_W-1:0]  idx_q;
	speed_t                ref_q;
	slip_t                 slip_q;
	logic [11:0]           total_q;
	logic [2:0]            count_q;
	logic                  avg_phase_q;
	logic                  sys_q;
	logic [NUM_WHEELS-1:0] pulse_q;
	slip_t                 avg_q;
	demand_t               bout_q [NUM_WHEELS];

	// divider
	logic [DEN_W-1:0]  div_rem_q;
	logic [SLIP_W-1:0] div_lo_q;
	logic [SLIP_W-1:0] div_quo_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [3:0]        div_cnt_q;

	logic s_acc;
	logic m_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign s_acc = s_tvalid & s_tready;
	assign m_acc = m_tvalid & m_tready;

	// reference speed: max over healthy wheels above the valid floor
	speed_t ref_c;
	always_comb begin
		ref_c = '0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (ok_q[i] && spd_q[i] > MIN_VALID_SPEED && spd_q[i] > ref_c) begin
				ref_c = spd_q[i];
			end
		end
	end

	// divider step
	logic [DEN_W+1:0] div_diff;
	logic             div_ge;
	logic [DEN_W:0]   div_shift;
	assign div_shift = {div_rem_q, div_lo_q[SLIP_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, div_den_q};
	assign div_ge    = ~div_diff[DEN_W+1];

	// slip dividend: (ref - w) * 1000 by shift and subtract
	speed_t           cur_spd;
	logic [DVD_W-1:0] sdiff;
	logic [DVD_W-1:0] slip_dvd;
	assign cur_spd  = spd_q[idx_q];
	assign sdiff    = {{(DVD_W-SPEED_W){1'b0}}, ref_q - cur_spd};
	assign slip_dvd = (sdiff << 10) - (sdiff << 4) - (sdiff << 3);

	// wheel update decisions
	logic [13:0] slip_x10;
	logic [13:0] thr_x7;
	time_t       lpt_eff;
	time_t       elapsed;
	logic        over_thr;
	logic        pulse_now;
	assign slip_x10  = ({4'b0, slip_q} << 3) + ({4'b0, slip_q} << 1);
	assign thr_x7    = ({4'b0, thr_q} << 3) - {4'b0, thr_q};
	assign over_thr  = slip_q > thr_q;
	assign lpt_eff   = active_q[idx_q] ? lpt_q[idx_q] : now_q;
	assign elapsed   = now_q - lpt_eff;
	assign pulse_now = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_q};

	// brake scaling
	logic [CUT_W-1:0] cut_sat;
	logic [CUT_W-1:0] keep;
	logic [20:0]      bprod;
	assign cut_sat = (cut_q > CUT_FULL) ? CUT_FULL : cut_q;
	assign keep    = CUT_FULL - cut_sat;
	assign bprod   = {9'b0, dem_q[idx_q]} * {12'b0, keep};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b1;
			thr_q       <= 10'd200;
			min_speed_q <= 16'd500;
			period_q    <= 16'd100;
			cut_q       <= 9'd77;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ABS_ENABLED:     enabled_q   <= cfg_data[0];
				REG_SLIP_THRESHOLD:  thr_q       <= cfg_data[THR_W-1:0];
				REG_MIN_SPEED:       min_speed_q <= cfg_data[SPEED_W-1:0];
				REG_PULSE_PERIOD_MS: period_q    <= cfg_data[PERIOD_W-1:0];
				REG_PRESSURE_CUT:    cut_q       <= cfg_data[CUT_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				spd_q[i] <= s_tdata[i*SPEED_W +: SPEED_W];
				dem_q[i] <= s_tdata[100 + i*DEMAND_W +: DEMAND_W];
			end
			ok_q  <= s_tdata[67:64];
			now_q <= s_tdata[99:68];
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			idx_q       <= '0;
			avg_phase_q <= 1'b0;
			div_cnt_q   <= '0;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				lpt_q[i]  <= '0;
				held_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_REF;
					end
				end
				ST_REF: begin
					idx_q <= '0;
					if (!enabled_q) begin
						state_q <= ST_BRAKE;
					end else if (ref_c < min_speed_q) begin
						active_q <= '0;
						for (int i = 0; i < NUM_WHEELS; i++) begin
							held_q[i] <= '0;
						end
						state_q <= ST_BRAKE;
					end else begin
						state_q <= ST_WHEEL;
					end
				end
				ST_WHEEL: begin
					if (!ok_q[idx_q]) begin
						if (idx_q == WHL_IDX_W'(NUM_WHEELS - 1)) begin
							state_q <= ST_AVG;
						end
						idx_q <= idx_q + 1'b1;
					end else if (cur_spd >= ref_q) begin
						state_q <= ST_UPD;
					end else begin
						div_cnt_q   <= '0;
						avg_phase_q <= 1'b0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					// wheel index is kept for the update; the mean pass already sits at zero
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 4'(SLIP_W - 1)) begin
						state_q <= avg_phase_q ? ST_BRAKE : ST_UPD;
					end
				end
				ST_UPD: begin
					held_q[idx_q] <= slip_q;
					if (over_thr) begin
						active_q[idx_q] <= 1'b1;
						if (!active_q[idx_q] || pulse_now) begin
							lpt_q[idx_q] <= now_q;
						end
					end else if (active_q[idx_q] && slip_x10 < thr_x7) begin
						active_q[idx_q] <= 1'b0;
					end
					if (idx_q == WHL_IDX_W'(NUM_WHEELS - 1)) begin
						state_q <= ST_AVG;
					end else begin
						state_q <= ST_WHEEL;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_AVG: begin
					idx_q <= '0;
					if (count_q != '0) begin
						div_cnt_q   <= '0;
						avg_phase_q <= 1'b1;
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_BRAKE;
					end
				end
				ST_BRAKE: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == WHL_IDX_W'(NUM_WHEELS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_acc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and divider datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					total_q <= '0;
					count_q <= '0;
					sys_q   <= 1'b0;
					pulse_q <= '0;
					avg_q   <= '0;
				end
			end
			ST_REF: begin
				ref_q <= ref_c;
			end
			ST_WHEEL: begin
				slip_q    <= '0;
				div_rem_q <= slip_dvd[DVD_W-1:SLIP_W];
				div_lo_q  <= slip_dvd[SLIP_W-1:0];
				div_den_q <= ref_q;
			end
			ST_DIV: begin
				div_rem_q <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
				div_lo_q  <= {div_lo_q[SLIP_W-2:0], 1'b0};
				div_quo_q <= {div_quo_q[SLIP_W-2:0], div_ge};
				if (div_cnt_q == 4'(SLIP_W - 1)) begin
					if (avg_phase_q) begin
						avg_q <= {div_quo_q[SLIP_W-2:0], div_ge};
					end else begin
						slip_q <= {div_quo_q[SLIP_W-2:0], div_ge};
					end
				end
			end
			ST_UPD: begin
				total_q <= total_q + {2'b0, slip_q};
				count_q <= count_q + 1'b1;
				if (over_thr) begin
					sys_q <= 1'b1;
					if (pulse_now) begin
						pulse_q[idx_q] <= 1'b1;
					end
				end
			end
			ST_AVG: begin
				// the top two bits of the total seed the remainder, the rest shift in
				div_rem_q <= {{(DEN_W-2){1'b0}}, total_q[11:SLIP_W]};
				div_lo_q  <= total_q[SLIP_W-1:0];
				div_den_q <= {13'b0, count_q};
			end
			ST_BRAKE: begin
				if (enabled_q && active_q[idx_q]) begin
					bout_q[idx_q] <= bprod[19:8];
				end else begin
					bout_q[idx_q] <= dem_q[idx_q];
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	assign m_tdata = {5'b0,
		bout_q[3], bout_q[2], bout_q[1], bout_q[0],
		avg_q,
		held_q[3], held_q[2], held_q[1], held_q[0],
		pulse_q, active_q, sys_q};

endmodule
